FILE: rtl/core/spcl_pkg.sv
package spcl_pkg;

  // Number of PWM duty channels that a 'P' command may address.
  localparam int CHANNELS = 8;

  // Frame and command bytes.
  localparam logic [7:0] HDR_BYTE = 8'h43;
  localparam logic [7:0] CMD_PWM  = 8'h50;
  localparam logic [7:0] CMD_LED  = 8'h4C;

  // Reset values of the configuration registers.
  localparam logic [15:0] SILENCE_LIMIT_RESET = 16'd10000;
  localparam logic [15:0] DUTY_LIMIT_RESET    = 16'd2000;

  // Largest value of the saturating silence counter.
  localparam logic [16:0] SIL_MAX = 17'h1FFFF;

  // Register indexes on the configuration port.
  localparam logic REG_SILENCE_LIMIT = 1'b0;
  localparam logic REG_DUTY_LIMIT    = 1'b1;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DUTY     = 3'd1,
    EV_LED      = 3'd2,
    EV_FAILSAFE = 3'd3,
    EV_IGNORED  = 3'd4
  } event_t;

  // What the front part has made of one input beat.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  // One queue entry: the class of the beat and a snapshot of the payload.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] p3;
  } entry_t;

  // Configuration registers as seen by the back part.
  typedef struct packed {
    logic [15:0] silence_limit;
    logic [15:0] duty_limit;
  } cfg_t;

  // Queue handshake between the parts.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/core/serial_pwm_command_link_with_failsafe.sv
// Serial PWM command link with failsafe.
//
// The input channel (in_valid, in_stall) carries one beat per received serial
// byte (operation 0, rx_byte) or per millisecond tick (operation 1). A beat is
// taken when in_valid is high and in_stall is low. Every beat gives exactly one
// result beat on the output channel (out_valid, out_stall): the event code, the
// channel and duty written, the LED states and the control mode after it.
//
// The front part runs the framer and places each classified beat in a
// two-entry queue; the back part carries out commands and ticks and holds the
// result in an output register. Each result passes through the queue and then
// the output register; one beat per cycle is sustained while out_stall is low.
//
// While out_stall is high the result register holds; the queue absorbs two
// more beats, and then in_stall rises until the receiver takes a result.
// Reset clears the framer, the queue, the mode, LEDs and silence counter, and
// sets silence_limit to 10000 and duty_limit to 2000. The APB port writes
// silence_limit at address 0 and duty_limit at address 4.
module serial_pwm_command_link_with_failsafe (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [2:0]  pwm_channel,
  output logic [15:0] pwm_duty,
  output logic        led0_on,
  output logic        led1_on,
  output logic        control_mode,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  spcl_pkg::cfg_t    cfg;
  spcl_pkg::q_ctrl_t q_ctrl;
  spcl_pkg::q_stat_t q_stat;
  spcl_pkg::entry_t  push_entry;
  spcl_pkg::entry_t  head;
  logic              push;
  logic              pop;
  logic              cfg_write;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.silence_limit <= spcl_pkg::SILENCE_LIMIT_RESET;
      cfg.duty_limit    <= spcl_pkg::DUTY_LIMIT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == spcl_pkg::REG_SILENCE_LIMIT) begin
        cfg.silence_limit <= pwdata[15:0];
      end else begin
        cfg.duty_limit <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == spcl_pkg::REG_SILENCE_LIMIT) ?
                  {16'd0, cfg.silence_limit} : {16'd0, cfg.duty_limit};

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  spcl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .rx_byte    (rx_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  spcl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .q_ctrl     (q_ctrl),
    .push_entry (push_entry),
    .q_stat     (q_stat),
    .head       (head)
  );

  spcl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .pwm_channel  (pwm_channel),
    .pwm_duty     (pwm_duty),
    .led0_on      (led0_on),
    .led1_on      (led1_on),
    .control_mode (control_mode)
  );

endmodule

FILE: rtl/core/spcl_front.sv
module spcl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [7:0]         rx_byte,
  input  spcl_pkg::q_stat_t  q_stat,
  output logic               push,
  output spcl_pkg::entry_t   push_entry
);

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_SIZE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] frame_length;
  logic [7:0] frame_length_next;
  logic [7:0] bytes_taken;
  logic [7:0] bytes_taken_next;
  logic [7:0] payload [4];
  logic [7:0] payload_next [4];
  logic       accept;

  // The front stalls only when the queue has no room.
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign push     = accept;

  // Framer: classify the beat and update the frame state.
  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_taken_next  = bytes_taken;
    payload_next      = payload;
    push_entry.kind   = spcl_pkg::KIND_NONE;
    if (operation) begin
      push_entry.kind = spcl_pkg::KIND_TICK;
    end else begin
      case (phase)
        PH_SIZE: begin
          frame_length_next = rx_byte;
          bytes_taken_next  = 8'd0;
          phase_next        = PH_BODY;
        end
        PH_BODY: begin
          if (bytes_taken < 8'd4) begin
            payload_next[bytes_taken[1:0]] = rx_byte;
          end
          bytes_taken_next = bytes_taken + 8'd1;
          if (bytes_taken_next >= frame_length) begin
            phase_next      = PH_HEAD;
            push_entry.kind = spcl_pkg::KIND_CMD;
          end
        end
        default: begin
          phase_next = (rx_byte == spcl_pkg::HDR_BYTE) ? PH_SIZE : PH_HEAD;
        end
      endcase
    end
    push_entry.p0 = payload_next[0];
    push_entry.p1 = payload_next[1];
    push_entry.p2 = payload_next[2];
    push_entry.p3 = payload_next[3];
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEAD;
      frame_length <= 8'd0;
      bytes_taken  <= 8'd0;
      for (int i = 0; i < 4; i++) begin
        payload[i] <= 8'd0;
      end
    end else if (accept) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      bytes_taken  <= bytes_taken_next;
      payload      <= payload_next;
    end
  end

endmodule

FILE: rtl/core/spcl_queue.sv
module spcl_queue (
  input  logic              clk,
  input  logic              rst,
  input  spcl_pkg::q_ctrl_t q_ctrl,
  input  spcl_pkg::entry_t  push_entry,
  output spcl_pkg::q_stat_t q_stat,
  output spcl_pkg::entry_t  head
);

  spcl_pkg::entry_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign head         = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (q_ctrl.push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_ctrl.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_ctrl.pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({q_ctrl.push, q_ctrl.pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/spcl_back.sv
module spcl_back (
  input  logic              clk,
  input  logic              rst,
  input  spcl_pkg::cfg_t    cfg,
  input  spcl_pkg::q_stat_t q_stat,
  input  spcl_pkg::entry_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        event_res,
  output logic [2:0]        pwm_channel,
  output logic [15:0]       pwm_duty,
  output logic              led0_on,
  output logic              led1_on,
  output logic              control_mode
);

  logic            mode_now;
  logic            mode_now_next;
  logic            mode_before_loss;
  logic            mode_before_loss_next;
  logic [16:0]     silent_ticks;
  logic [16:0]     silent_ticks_next;
  logic [1:0]      leds;
  logic [1:0]      leds_next;
  spcl_pkg::event_t ev_next;
  logic [2:0]      chan_next;
  logic [15:0]     duty_next;
  logic [15:0]     req_duty;
  logic            led_sel;

  // Take the next entry whenever the output register is free or being emptied.
  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  assign req_duty = {head.p2, head.p3};
  assign led_sel  = head.p1[0];

  // Carry out one entry against the control state.
  always_comb begin
    mode_now_next         = mode_now;
    mode_before_loss_next = mode_before_loss;
    silent_ticks_next     = silent_ticks;
    leds_next             = leds;
    ev_next               = spcl_pkg::EV_NONE;
    chan_next             = 3'd0;
    duty_next             = 16'd0;
    case (head.kind)
      spcl_pkg::KIND_TICK: begin
        if (silent_ticks != spcl_pkg::SIL_MAX) begin
          silent_ticks_next = silent_ticks + 17'd1;
        end
        if ((silent_ticks_next > {1'b0, cfg.silence_limit}) && mode_now) begin
          mode_before_loss_next = mode_now;
          mode_now_next         = 1'b0;
          leds_next[0]          = 1'b1;
          ev_next               = spcl_pkg::EV_FAILSAFE;
        end
      end
      spcl_pkg::KIND_CMD: begin
        silent_ticks_next = 17'd0;
        // Leaving the no-signal mode restores the remembered mode.
        if (!mode_now) begin
          mode_now_next = mode_before_loss;
          leds_next[0]  = 1'b0;
        end
        if (head.p0 == spcl_pkg::CMD_PWM) begin
          mode_now_next = 1'b1;
          if ((head.p1 < 8'(spcl_pkg::CHANNELS)) && (req_duty <= cfg.duty_limit)) begin
            ev_next   = spcl_pkg::EV_DUTY;
            chan_next = head.p1[2:0];
            duty_next = req_duty;
          end else begin
            ev_next = spcl_pkg::EV_IGNORED;
          end
        end else if (head.p0 == spcl_pkg::CMD_LED) begin
          if (head.p1 > 8'd1) begin
            ev_next = spcl_pkg::EV_IGNORED;
          end else begin
            leds_next[led_sel] = (head.p2 != 8'd0);
            ev_next            = spcl_pkg::EV_LED;
          end
        end else begin
          ev_next = spcl_pkg::EV_IGNORED;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_now         <= 1'b0;
      mode_before_loss <= 1'b0;
      silent_ticks     <= 17'd0;
      leds             <= 2'b00;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        mode_now         <= mode_now_next;
        mode_before_loss <= mode_before_loss_next;
        silent_ticks     <= silent_ticks_next;
        leds             <= leds_next;
        out_valid        <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      event_res    <= ev_next;
      pwm_channel  <= chan_next;
      pwm_duty     <= duty_next;
      led0_on      <= leds_next[0];
      led1_on      <= leds_next[1];
      control_mode <= mode_now_next;
    end
  end

endmodule

FILE: tb/link_tb_pkg.sv
`timescale 1ns / 100ps

package link_tb_pkg;

  // Meaning of the operation field of an input beat.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage

FILE: tb/pwm_link_checker.sv
`timescale 1ns / 100ps

module pwm_link_checker
  import spcl_pkg::*;
  import link_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  event_res,
  input  logic [2:0]  pwm_channel,
  input  logic [15:0] pwm_duty,
  input  logic        led0_on,
  input  logic        led1_on,
  input  logic        control_mode,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  typedef enum logic [1:0] {
    FR_HEAD = 2'd0,
    FR_SIZE = 2'd1,
    FR_BODY = 2'd2
  } framer_t;

  // What one output beat should carry.
  typedef struct packed {
    event_t      ev;
    logic [2:0]  chan;
    logic [15:0] duty;
    logic        led0;
    logic        led1;
    logic        mode;
  } link_result_t;

  link_result_t results_due[$];

  // Shadow of the configuration registers and of the link state.
  logic [15:0] silence_limit;
  logic [15:0] duty_limit;
  framer_t     phase;
  logic [7:0]  frame_len;
  logic [7:0]  taken;
  logic [7:0]  payload[4];
  logic [15:0] duty_reg[CHANNELS];
  logic        mode;
  logic        mode_saved;
  logic [16:0] silence;
  logic [1:0]  leds;
  int          fail_tally = 0;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
    fail_tally++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Carry out a completed frame held in the payload bytes.
  task automatic run_command(inout link_result_t r);
    logic [7:0]  op_byte;
    logic [15:0] d;
    op_byte = payload[0];
    d = {payload[2], payload[3]};
    silence = '0;
    // A command after signal loss brings back the mode held before it.
    if (!mode) begin
      mode = mode_saved;
      leds[0] = 1'b0;
    end
    if (op_byte == CMD_PWM) begin
      mode = 1'b1;
      if (payload[1] < CHANNELS && d <= duty_limit) begin
        duty_reg[payload[1][2:0]] = d;
        r.ev = EV_DUTY;
        r.chan = payload[1][2:0];
        r.duty = d;
      end else begin
        r.ev = EV_IGNORED;
      end
    end else if (op_byte == CMD_LED && payload[1] <= 8'd1) begin
      leds[payload[1][0]] = (payload[2] != 8'd0);
      r.ev = EV_LED;
    end else begin
      r.ev = EV_IGNORED;
    end
  endtask

  // Advance the shadow state by one input beat and form its result.
  task automatic predict_beat(input logic op, input logic [7:0] value,
                              output link_result_t r);
    r = '0;
    r.ev = EV_NONE;
    if (op == OP_TICK) begin
      if (silence < SIL_MAX) begin
        silence++;
      end
      if (silence > {1'b0, silence_limit} && mode) begin
        mode_saved = mode;
        mode = 1'b0;
        foreach (duty_reg[i]) duty_reg[i] = '0;
        leds[0] = 1'b1;
        r.ev = EV_FAILSAFE;
      end
    end else begin
      case (phase)
        FR_SIZE: begin
          frame_len = value;
          taken = '0;
          phase = FR_BODY;
        end
        FR_BODY: begin
          // Bytes past the fourth are counted but not kept.
          if (taken < 8'd4) begin
            payload[taken[1:0]] = value;
          end
          taken++;
          if (taken >= frame_len) begin
            phase = FR_HEAD;
            run_command(r);
          end
        end
        default: begin
          phase = (value == HDR_BYTE) ? FR_SIZE : FR_HEAD;
        end
      endcase
    end
    r.led0 = leds[0];
    r.led1 = leds[1];
    r.mode = mode;
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin : watch
    link_result_t fresh;
    link_result_t due;
    if (rst) begin
      silence_limit = SILENCE_LIMIT_RESET;
      duty_limit = DUTY_LIMIT_RESET;
      phase = FR_HEAD;
      frame_len = '0;
      taken = '0;
      foreach (payload[i]) payload[i] = '0;
      foreach (duty_reg[i]) duty_reg[i] = '0;
      mode = 1'b0;
      mode_saved = 1'b0;
      silence = '0;
      leds = '0;
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SILENCE_LIMIT) begin
          silence_limit = pwdata[15:0];
        end else begin
          duty_limit = pwdata[15:0];
        end
      end
      // Compare before queueing, so that a result cannot match its own input.
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing expected, event", 16'(event_res), '0);
        end else begin
          due = results_due.pop_front();
          check_field("event_res", 16'(event_res), 16'(due.ev));
          check_field("pwm_channel", 16'(pwm_channel), 16'(due.chan));
          check_field("pwm_duty", pwm_duty, due.duty);
          check_field("led0_on", 16'(led0_on), 16'(due.led0));
          check_field("led1_on", 16'(led1_on), 16'(due.led1));
          check_field("control_mode", 16'(control_mode), 16'(due.mode));
        end
      end
      if (in_valid && !in_stall) begin
        predict_beat(operation, rx_byte, fresh);
        results_due.push_back(fresh);
      end
    end
    mismatches <= fail_tally;
    outstanding <= results_due.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import spcl_pkg::*;
  import link_tb_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_BEATS = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        operation = OP_BYTE;
  logic [7:0]  rx_byte = '0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        in_stall;
  logic        out_valid;
  logic [2:0]  event_res;
  logic [2:0]  pwm_channel;
  logic [15:0] pwm_duty;
  logic        led0_on;
  logic        led1_on;
  logic        control_mode;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          outstanding;
  logic        calm = 1'b0;
  int          quiet_cycles = 0;
  int          beats_sent = 0;
  int          frames_sent = 0;
  int          ticks_sent = 0;
  int          settings_used = 0;
  logic [15:0] cur_duty_limit = DUTY_LIMIT_RESET;
  logic [7:0]  frame_body[$];

  // Register settings visited by the random phases, extremes included.
  logic [15:0] silence_set[6] = '{16'd3, 16'd0, 16'd20, 16'd65535, 16'd1, 16'd8};
  logic [15:0] duty_set[6] = '{16'd65535, 16'd0, 16'd1000, 16'd2000, 16'd255, 16'd12345};

  always #10 clk = ~clk;

  serial_pwm_command_link_with_failsafe dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .pwm_channel(pwm_channel), .pwm_duty(pwm_duty),
    .led0_on(led0_on), .led1_on(led1_on), .control_mode(control_mode),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pwm_link_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .pwm_channel(pwm_channel), .pwm_duty(pwm_duty),
    .led0_on(led0_on), .led1_on(led1_on), .control_mode(control_mode),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // The receiver holds off result beats at random, except in calm stretches.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 38);
  end

  // Watchdog: give up when no beat or register write has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one input beat, after a random gap, and hold it until it is taken.
  task automatic send_beat(input logic op, input logic [7:0] value);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    rx_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_tick();
    send_beat(OP_TICK, 8'($urandom_range(0, 255)));
    ticks_sent++;
  endtask

  // Header, length, then the body bytes, with ticks slipped in between.
  task automatic send_frame(input logic [7:0] length, input int tick_pct);
    send_beat(OP_BYTE, HDR_BYTE);
    send_beat(OP_BYTE, length);
    for (int i = 0; i < frame_body.size(); i++) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        send_tick();
      end
      send_beat(OP_BYTE, frame_body[i]);
    end
    frames_sent++;
  endtask

  // Build a mostly well-formed frame with random content and send it.
  task automatic random_frame();
    logic [7:0]  cmd;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [15:0] duty;
    int          len;
    int          pick;
    pick = $urandom_range(0, 9);
    c = 8'($urandom_range(0, 255));
    if (pick < 5) begin
      cmd = CMD_PWM;
      a = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, CHANNELS - 1))
                                     : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0: duty = 16'($urandom_range(0, 65535));
        1: duty = cur_duty_limit + 16'($urandom_range(0, 4)) - 16'd2;
        default: duty = 16'($urandom_range(0, cur_duty_limit));
      endcase
      b = duty[15:8];
      c = duty[7:0];
      len = 4;
    end else if (pick < 8) begin
      cmd = CMD_LED;
      a = ($urandom_range(0, 9) < 9) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
      b = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(1, 255));
      len = 3;
    end else begin
      cmd = 8'($urandom_range(0, 255));
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      len = $urandom_range(1, 4);
    end
    // Now and then a short frame (stale bytes), a long one, or a very long one.
    pick = $urandom_range(0, 39);
    if (pick < 3) begin
      len = $urandom_range(0, 3);
    end else if (pick < 6) begin
      len = $urandom_range(5, 12);
    end else if (pick == 6) begin
      len = $urandom_range(13, 255);
    end
    frame_body = '{cmd, a, b, c};
    while (frame_body.size() > ((len == 0) ? 1 : len)) frame_body.pop_back();
    while (frame_body.size() < len) frame_body.push_back(8'($urandom_range(0, 255)));
    // A broken frame ends early, so the next bytes land in its body.
    if ($urandom_range(0, 14) == 0) begin
      frame_body.pop_back();
    end
    send_frame(8'(len), 12);
  endtask

  // Let every expected result drain, with a margin after it.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the caller closes the transfer.
  task automatic reg_write(input logic regsel, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= {16'($urandom_range(0, 65535)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic random_phase(input int quota, input logic [15:0] sil);
    int target;
    int pick;
    int burst_max;
    target = beats_sent + quota;
    burst_max = (sil < 16'd30) ? int'(sil) + 3 : 8;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        random_frame();
      end else if (pick < 85) begin
        repeat ($urandom_range(1, burst_max)) send_tick();
      end else begin
        send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats at the reset settings: stray bytes, a tick, a duty at the
    // limit and one over it, an LED write, an empty frame with an unknown
    // command, and a short frame that reuses the earlier payload.
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'hFF);
    send_tick();
    frame_body = '{CMD_PWM, 8'd0, 8'h07, 8'hD0};
    send_frame(8'd4, 0);
    frame_body = '{CMD_PWM, 8'd7, 8'h07, 8'hD1};
    send_frame(8'd4, 0);
    frame_body = '{CMD_LED, 8'd1, 8'hFF};
    send_frame(8'd3, 0);
    frame_body = '{8'h51};
    send_frame(8'd0, 0);
    frame_body = '{CMD_LED};
    send_frame(8'd1, 0);

    // Random phases, one per register setting.
    foreach (silence_set[i]) begin
      wait_idle();
      reg_write(REG_SILENCE_LIMIT, silence_set[i]);
      reg_write(REG_DUTY_LIMIT, duty_set[i]);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cur_duty_limit = duty_set[i];
      settings_used++;
      // One whole phase runs with neither side holding back.
      calm <= (i == 2);
      random_phase(PHASE_BEATS, silence_set[i]);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d input beats: %0d frames and %0d ticks, over %0d register settings",
             beats_sent, frames_sent, ticks_sent, settings_used + 1);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/spcl_pkg.sv
rtl/core/spcl_front.sv
rtl/core/spcl_queue.sv
rtl/core/spcl_back.sv
rtl/core/serial_pwm_command_link_with_failsafe.sv
tb/link_tb_pkg.sv
tb/pwm_link_checker.sv
tb/tb.sv
